FILE: rtl/core/jsu_pkg.sv
// shared types, character codes and the utf-8 encoder of the json string unescaper
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_NEED_BS = 3'd4,
    MODE_NEED_U  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_QUOTE = 3'd1,
    ERR_NUL      = 3'd2,
    ERR_CTRL     = 3'd3,
    ERR_ESC      = 3'd4,
    ERR_HEX      = 3'd5,
    ERR_SURR     = 3'd6
  } err_e;

  // characters the decoder looks for
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // control codes the short escapes stand for
  localparam logic [7:0] CC_BS = 8'h08;
  localparam logic [7:0] CC_HT = 8'h09;
  localparam logic [7:0] CC_LF = 8'h0A;
  localparam logic [7:0] CC_FF = 8'h0C;
  localparam logic [7:0] CC_CR = 8'h0D;

  // utf-16 surrogate ranges
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // utf-8 length limits and lead byte marks
  localparam logic [20:0] MAX_1BYTE = 21'h00007F;
  localparam logic [20:0] MAX_2BYTE = 21'h0007FF;
  localparam logic [20:0] MAX_3BYTE = 21'h00FFFF;
  localparam logic [7:0]  LEAD_2    = 8'hC0;
  localparam logic [7:0]  LEAD_3    = 8'hE0;
  localparam logic [7:0]  LEAD_4    = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;

  // up to four results caused by one input byte
  typedef struct packed {
    logic            valid;    // at least one result
    logic [3:0][7:0] bytes;    // data bytes in output order
    logic [1:0]      last_idx; // index of the final result
    logic            is_data;
    logic            done;
    err_e            err;
  } bundle_t;

  function automatic bundle_t utf8_encode(input logic [20:0] cp);
    bundle_t b;
    b         = '0;
    b.valid   = 1'b1;
    b.is_data = 1'b1;
    b.err     = ERR_NONE;
    if (cp <= MAX_1BYTE) begin
      b.bytes[0] = cp[7:0];
      b.last_idx = 2'd0;
    end else if (cp <= MAX_2BYTE) begin
      b.bytes[0] = LEAD_2 | {3'b000, cp[10:6]};
      b.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      b.last_idx = 2'd1;
    end else if (cp <= MAX_3BYTE) begin
      b.bytes[0] = LEAD_3 | {4'b0000, cp[15:12]};
      b.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      b.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      b.last_idx = 2'd2;
    end else begin
      b.bytes[0] = LEAD_4 | {5'b00000, cp[20:18]};
      b.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      b.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      b.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      b.last_idx = 2'd3;
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/jsu_decode.sv
// escape decoder: parser state and the results of one input byte
module jsu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      byte_i,
  output jsu_pkg::bundle_t bundle_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [15:0] high_unit_q, high_unit_d;
  logic [15:0] hex_accum_q, hex_accum_d;
  logic        in_low_q, in_low_d;

  logic        hex_ok;
  logic [3:0]  hex_dig;
  logic [15:0] acc_next;
  logic        hex_final;
  logic        acc_high;
  logic        acc_low;
  logic [20:0] pair_cp;
  logic        short_esc;
  logic [7:0]  short_byte;

  // hex digit value
  always_comb begin
    hex_ok  = 1'b0;
    hex_dig = byte_i[3:0];
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((byte_i >= 8'h41 && byte_i <= 8'h46) ||
                 (byte_i >= 8'h61 && byte_i <= 8'h66)) begin
      hex_ok  = 1'b1;
      hex_dig = byte_i[3:0] + 4'd9;
    end
  end

  assign acc_next  = {hex_accum_q[11:0], hex_dig};
  assign hex_final = (hex_count_q == 2'd3);
  assign acc_high  = (acc_next >= HI_SURR_MIN) && (acc_next <= HI_SURR_MAX);
  assign acc_low   = (acc_next >= LO_SURR_MIN) && (acc_next <= LO_SURR_MAX);
  assign pair_cp   = SUPP_BASE + {1'b0, high_unit_q[9:0], acc_next[9:0]};

  // short escapes
  always_comb begin
    short_esc  = 1'b1;
    short_byte = byte_i;
    unique case (byte_i)
      CH_QUOTE, CH_BSLASH, CH_SLASH: short_byte = byte_i;
      CH_B:    short_byte = CC_BS;
      CH_F:    short_byte = CC_FF;
      CH_N:    short_byte = CC_LF;
      CH_R:    short_byte = CC_CR;
      CH_T:    short_byte = CC_HT;
      default: short_esc  = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_d      = mode_q;
    hex_count_d = hex_count_q;
    high_unit_d = high_unit_q;
    hex_accum_d = hex_accum_q;
    in_low_d    = in_low_q;
    unique case (mode_q)
      MODE_IDLE: begin
        hex_count_d = '0;
        high_unit_d = '0;
        hex_accum_d = '0;
        in_low_d    = 1'b0;
        mode_d      = (byte_i == CH_QUOTE) ? MODE_STR : MODE_IDLE;
      end
      MODE_STR: begin
        if (byte_i == CH_BSLASH) begin
          mode_d = MODE_ESC;
        end else if (byte_i == CH_QUOTE || byte_i < CH_SPACE) begin
          mode_d      = MODE_IDLE;
          hex_count_d = '0;
          high_unit_d = '0;
          hex_accum_d = '0;
          in_low_d    = 1'b0;
        end
      end
      MODE_ESC: begin
        if (byte_i == CH_U) begin
          mode_d      = MODE_HEX;
          hex_count_d = '0;
          hex_accum_d = '0;
          in_low_d    = 1'b0;
        end else if (short_esc) begin
          mode_d = MODE_STR;
        end else begin
          mode_d      = MODE_IDLE;
          hex_count_d = '0;
          high_unit_d = '0;
          hex_accum_d = '0;
          in_low_d    = 1'b0;
        end
      end
      MODE_HEX: begin
        if (!hex_ok || (hex_final && in_low_q && !acc_low)) begin
          mode_d      = MODE_IDLE;
          hex_count_d = '0;
          high_unit_d = '0;
          hex_accum_d = '0;
          in_low_d    = 1'b0;
        end else begin
          hex_accum_d = acc_next;
          if (!hex_final) begin
            hex_count_d = hex_count_q + 2'd1;
          end else begin
            hex_count_d = '0;
            if (!in_low_q && acc_high) begin
              high_unit_d = acc_next;
              mode_d      = MODE_NEED_BS;
            end else begin
              mode_d   = MODE_STR;
              in_low_d = 1'b0;
            end
          end
        end
      end
      MODE_NEED_BS, MODE_NEED_U: begin
        if (mode_q == MODE_NEED_BS && byte_i == CH_BSLASH) begin
          mode_d = MODE_NEED_U;
        end else if (mode_q == MODE_NEED_U && byte_i == CH_U) begin
          mode_d      = MODE_HEX;
          hex_count_d = '0;
          hex_accum_d = '0;
          in_low_d    = 1'b1;
        end else begin
          mode_d      = MODE_IDLE;
          hex_count_d = '0;
          high_unit_d = '0;
          hex_accum_d = '0;
          in_low_d    = 1'b0;
        end
      end
      default: begin
        mode_d      = MODE_IDLE;
        hex_count_d = '0;
        high_unit_d = '0;
        hex_accum_d = '0;
        in_low_d    = 1'b0;
      end
    endcase
  end

  // results of this byte
  always_comb begin
    bundle_o     = '0;
    bundle_o.err = ERR_NONE;
    unique case (mode_q)
      MODE_IDLE: begin
        if (byte_i != CH_QUOTE) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_NO_QUOTE;
        end
      end
      MODE_STR: begin
        if (byte_i == CH_QUOTE) begin
          bundle_o.valid = 1'b1;
          bundle_o.done  = 1'b1;
        end else if (byte_i == CH_BSLASH) begin
          bundle_o.valid = 1'b0;
        end else if (byte_i == CH_NUL) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_NUL;
        end else if (byte_i < CH_SPACE) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_CTRL;
        end else begin
          bundle_o.valid    = 1'b1;
          bundle_o.is_data  = 1'b1;
          bundle_o.bytes[0] = byte_i;
        end
      end
      MODE_ESC: begin
        if (short_esc) begin
          bundle_o.valid    = 1'b1;
          bundle_o.is_data  = 1'b1;
          bundle_o.bytes[0] = short_byte;
        end else if (byte_i != CH_U) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_ESC;
        end
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_HEX;
        end else if (hex_final) begin
          if (in_low_q) begin
            if (acc_low) begin
              bundle_o = utf8_encode(pair_cp);
            end else begin
              bundle_o.valid = 1'b1;
              bundle_o.err   = ERR_SURR;
            end
          end else if (!acc_high) begin
            bundle_o = utf8_encode({5'b00000, acc_next});
          end
        end
      end
      MODE_NEED_BS: begin
        if (byte_i != CH_BSLASH) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_SURR;
        end
      end
      MODE_NEED_U: begin
        if (byte_i != CH_U) begin
          bundle_o.valid = 1'b1;
          bundle_o.err   = ERR_SURR;
        end
      end
      default: begin
        bundle_o.valid = 1'b1;
        bundle_o.err   = ERR_NO_QUOTE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      hex_count_q <= '0;
      high_unit_q <= '0;
      hex_accum_q <= '0;
      in_low_q    <= 1'b0;
    end else if (take_i) begin
      mode_q      <= mode_d;
      hex_count_q <= hex_count_d;
      high_unit_q <= high_unit_d;
      hex_accum_q <= hex_accum_d;
      in_low_q    <= in_low_d;
    end
  end

endmodule

FILE: rtl/core/json_string_unescape_utf8.sv
// top level of the json string unescaper: decoder plus result register and byte serialiser
//
// input channel: one raw byte of a json string literal per request, opening quote first
// (in_valid_i / in_stall_o / in_byte_i). output channel: one result per request with
// has_byte_o / out_byte_o for decoded utf-8 bytes, last_o on the final result of an
// input byte, done_res_o on the closing quote and error_code_o for errors.
// an accepted byte is decoded in the same cycle and its results sit in the result
// register from the next cycle. throughput is one input byte per cycle while each
// byte yields at most one result and the receiver does not stall; a byte that
// yields k results (a \u escape, up to 4 bytes for a surrogate pair) holds the
// result register until all k of them, one utf-8 byte each, have left.
// bytes that yield no result (backslash, 'u', early hex digits) never reach the
// output. a new byte is taken in the same cycle as the final result of the previous
// one leaves, so both sides run back to back.
// when the receiver stalls, the held result stays unchanged and in_stall_o rises once
// the result register is full. reset leaves the parser idle waiting for the opening
// quote with the result register empty; any error also returns it to idle.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       done_res_o,
  output logic [2:0] error_code_o
);
  import jsu_pkg::*;

  bundle_t    new_bundle;
  bundle_t    bundle_q;
  logic [1:0] idx_q;
  logic       in_take;
  logic       out_take;
  logic       out_last;
  logic       finishing;

  // parser state lives in the decoder and moves only on an accepted request
  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_take),
    .byte_i   (in_byte_i),
    .bundle_o (new_bundle)
  );

  assign out_last  = (idx_q == bundle_q.last_idx);
  assign out_take  = bundle_q.valid && !out_stall_i;
  assign finishing = out_take && out_last;

  // room for a new byte when empty or when the final result leaves this cycle
  assign in_stall_o = bundle_q.valid && !finishing;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bundle_q <= '0;
      idx_q    <= '0;
    end else if (in_take) begin
      // a byte with no results leaves the register empty
      bundle_q <= new_bundle;
      idx_q    <= '0;
    end else if (finishing) begin
      bundle_q.valid <= 1'b0;
      idx_q          <= '0;
    end else if (out_take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // result fields; non-data results carry a zero byte
  assign out_valid_o  = bundle_q.valid;
  assign has_byte_o   = bundle_q.is_data;
  assign out_byte_o   = bundle_q.is_data ? bundle_q.bytes[idx_q] : 8'h00;
  assign last_o       = out_last;
  assign done_res_o   = bundle_q.done;
  assign error_code_o = bundle_q.err;

endmodule
